### rtl/assert_macros.svh
// Assertion macros shared by the serial line assembler RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SLA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SLA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sla_pkg.sv
// Package for the serial line assembler: sizes, byte codes, FSM and
// controller/datapath command and status types. No dependencies.
package sla_pkg;

   localparam int LINE_CAPACITY = 64;
   localparam int STORE_DEPTH   = 64;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int LEN_W         = ADDR_W + 1;
   localparam int CHAR_W        = 7;
   localparam int BYTE_W        = 8;

   localparam logic [LEN_W-1:0]  CAP_LEN   = LEN_W'(LINE_CAPACITY);

   localparam logic [BYTE_W-1:0] CH_LOW    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_HIGH   = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_DELETE = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_RETURN = 8'h0D;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic rd_en;    // read store at current emit index
      logic advance;  // output transfer this cycle
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_emit; // current input byte completes a line
      logic last;       // current emit index is the final char
   } status_type;

endpackage

### rtl/sla_ifs.sv
// Valid/ready stream interfaces for the serial line assembler channels.
// Depends on sla_pkg for payload widths.
interface sla_req_if import sla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              queue_has_room;

   modport source (output valid, output rx_byte, output queue_has_room, input ready);
   modport sink   (input valid, input rx_byte, input queue_has_room, output ready);
endinterface

interface sla_rsp_if import sla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic [ADDR_W-1:0] char_index;
   logic [LEN_W-1:0]  line_length;
   logic              last_char;

   modport source (output valid, output char_out, output char_index,
                   output line_length, output last_char, input ready);
   modport sink   (input valid, input char_out, input char_index,
                   input line_length, input last_char, output ready);
endinterface

### rtl/serial_line_assembler.sv
// Serial line assembler: one byte per input transfer; no output for most bytes.
// Bytes that end no line are taken back to back while idle. A line of N chars
// then drains one char at a time: store read (ST_READ), then output register
// (ST_EMIT, where the receiver may stall); input waits until the last char.
// Reset (synchronous, active high) empties the line and idles the FSM; the
// store itself is not cleared, only written entries are ever read.
`include "assert_macros.svh"
module serial_line_assembler import sla_pkg::*; (
   input logic       clock,
   input logic       reset,
   sla_req_if.sink   req_chan,
   sla_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   // sequencing: idle accepts bytes, read/emit states walk the line out
   sla_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // line store, fill count and output registers
   sla_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rx_byte        (req_chan.rx_byte),
      .queue_has_room (req_chan.queue_has_room),
      .status         (status),
      .char_out       (rsp_chan.char_out),
      .char_index     (rsp_chan.char_index),
      .line_length    (rsp_chan.line_length),
      .last_char      (rsp_chan.last_char)
   );

   // index always within the line while a char is offered
   `SLA_ASSERT(a_idx_in_line, clock, reset, rsp_chan.valid |-> ({1'b0, rsp_chan.char_index} < rsp_chan.line_length), "char index past line length")
   // after the final transfer of a line, input reopens
   `SLA_ASSERT(a_reopen, clock, reset, (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_char) |=> req_chan.ready, "input not reopened after line")
   // a non-final transfer is followed by more of the same line
   `SLA_ASSERT(a_continue, clock, reset, (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_char) |=> !req_chan.ready, "line cut short")

endmodule

### rtl/sla_datapath.sv
// Datapath: byte classification, fill count, line store and emit registers.
// Depends on sla_pkg; driven by sla_controller commands.
module sla_datapath import sla_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              queue_has_room,
   output status_type        status,
   output logic [CHAR_W-1:0] char_out,
   output logic [ADDR_W-1:0] char_index,
   output logic [LEN_W-1:0]  line_length,
   output logic              last_char
);

   logic [CHAR_W-1:0] line_store [STORE_DEPTH];

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CHAR_W-1:0] char_ff;

   logic              printable, is_delete, is_return;
   logic [LEN_W-1:0]  fill_plus;
   logic              wr_en;
   logic              last;

   assign printable = (rx_byte >= CH_LOW) && (rx_byte <= CH_HIGH);
   assign is_delete = (rx_byte == CH_DELETE);
   assign is_return = (rx_byte == CH_RETURN);
   assign fill_plus = {1'b0, fill_ff} + LEN_W'(1);
   assign wr_en     = cmd.accept && queue_has_room && printable;
   assign last      = (({1'b0, idx_ff} + LEN_W'(1)) == len_ff);

   assign status.start_emit = queue_has_room &&
                              ((printable && (fill_plus == CAP_LEN)) ||
                               (is_return && (fill_ff != '0)));
   assign status.last       = last;

   always_comb begin
      fill_in = fill_ff;
      len_in  = len_ff;
      idx_in  = idx_ff;
      if (cmd.accept && queue_has_room) begin
         if (status.start_emit) begin
            fill_in = '0;
            idx_in  = '0;
            len_in  = printable ? CAP_LEN : {1'b0, fill_ff};
         end else if (printable) begin
            fill_in = fill_plus[ADDR_W-1:0];
         end else if (is_delete && (fill_ff != '0)) begin
            fill_in = fill_ff - ADDR_W'(1);
         end
      end
      if (cmd.advance) begin
         idx_in = last ? '0 : idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
         len_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         idx_ff  <= idx_in;
         len_ff  <= len_in;
      end
   end

   // store: one write port (append), one registered read port (emit)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[fill_ff] <= rx_byte[CHAR_W-1:0];
      end
      if (cmd.rd_en) begin
         char_ff <= line_store[idx_ff];
      end
   end

   assign char_out    = char_ff;
   assign char_index  = idx_ff;
   assign line_length = len_ff;
   assign last_char   = last;

endmodule

### rtl/sla_controller.sv
// Controller FSM: takes bytes while idle, then walks the stored line out
// one character at a time. Depends on sla_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sla_controller import sla_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.start_emit) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) state_in = status.last ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SLA_ASSERT_ALWAYS(a_no_overlap, clock, !(req_ready && rsp_valid), "input taken while emitting")
   `SLA_ASSERT(a_read_then_emit, clock, reset, cmd.rd_en |=> rsp_valid, "emit did not follow read")
   `SLA_ASSERT(a_emit_start, clock, reset, (cmd.accept && status.start_emit) |=> cmd.rd_en, "line end did not start a read")

endmodule

### test/sla_line_checker.sv
// Scoreboard for the serial line assembler: watches both channels, predicts
// the characters of each completed line and compares them in order.
// Depends on sla_pkg and the stream interfaces in sla_ifs.sv.
module sla_line_checker import sla_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic flush_check,
   sla_req_if   req_tap,
   sla_rsp_if   rsp_tap,
   output int   mismatch_count,
   output int   chars_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic [ADDR_W-1:0] pos;
      logic [LEN_W-1:0]  len;
      logic              last;
   } line_char_type;

   logic [BYTE_W-1:0] line_buf [STORE_DEPTH];
   logic [LEN_W-1:0]  line_fill = '0;
   line_char_type     expected_chars [$];
   int                fails = 0;
   bit                flushed = 1'b0;

   task automatic report_mismatch(string msg);
      fails++;
      if (fails <= 40)
         $display("[%0t] line check: %s", $realtime, msg);
   endtask

   // Queue one expectation per stored character, then start a new line.
   task automatic queue_line();
      line_char_type c;
      for (int k = 0; k < int'(line_fill); k++) begin
         c.ch   = line_buf[k][CHAR_W-1:0];
         c.pos  = ADDR_W'(k);
         c.len  = line_fill;
         c.last = (k == int'(line_fill) - 1);
         expected_chars.push_back(c);
      end
      line_fill = '0;
   endtask

   task automatic take_byte(logic [BYTE_W-1:0] b, logic room);
      if (!room)
         return;
      if (b >= CH_LOW && b <= CH_HIGH) begin
         line_buf[line_fill[ADDR_W-1:0]] = b;
         line_fill++;
         if (line_fill >= CAP_LEN)
            queue_line();
      end else if (b == CH_DELETE) begin
         if (line_fill != 0)
            line_fill--;
      end else if (b == CH_RETURN && line_fill != 0) begin
         queue_line();
      end
   endtask

   task automatic check_char();
      line_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("char 0x%02h arrived with nothing expected",
                                   rsp_tap.char_out));
         return;
      end
      want = expected_chars.pop_front();
      if (rsp_tap.char_out !== want.ch)
         report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
                                   rsp_tap.char_out, want.ch));
      if (rsp_tap.char_index !== want.pos)
         report_mismatch($sformatf("char_index %0d, want %0d",
                                   rsp_tap.char_index, want.pos));
      if (rsp_tap.line_length !== want.len)
         report_mismatch($sformatf("line_length %0d, want %0d",
                                   rsp_tap.line_length, want.len));
      if (rsp_tap.last_char !== want.last)
         report_mismatch($sformatf("last_char %0b, want %0b at index %0d",
                                   rsp_tap.last_char, want.last, want.pos));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tap.valid && req_tap.ready)
            take_byte(req_tap.rx_byte, req_tap.queue_has_room);
         if (rsp_tap.valid && rsp_tap.ready)
            check_char();
         if (flush_check && !flushed) begin
            flushed = 1'b1;
            if (expected_chars.size() != 0)
               report_mismatch($sformatf("%0d expected chars never arrived",
                                         expected_chars.size()));
         end
      end
      mismatch_count    <= fails;
      chars_outstanding <= expected_chars.size();
   end

endmodule

### test/tb_top.sv
// Top of the serial line assembler testbench: clock, reset, byte stimulus,
// output back-pressure and the verdict. Depends on sla_pkg, sla_ifs.sv,
// the assembler RTL and sla_line_checker.
module tb_top import sla_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 90;
   localparam int HOLD_CYCLES  = 300;   // long output stall, see pressure phase
   localparam int DRAIN_CYCLES = 20;    // margin after the last line drains, before the flush check
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic clock;
   logic reset;
   logic flush_check;
   int   mismatch_count;
   int   chars_outstanding;
   int   cycle_count = 0;

   // Idle controls: the stimulus flips the first two per line so that some
   // stretches run back to back and others carry gaps on either side.
   bit   sender_idles;
   bit   receiver_stalls;
   bit   hold_request;
   bit   hold_active;

   sla_req_if req_chan ();
   sla_rsp_if rsp_chan ();

   serial_line_assembler dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sla_line_checker line_check (
      .clock             (clock),
      .reset             (reset),
      .flush_check       (flush_check),
      .req_tap           (req_chan),
      .rsp_tap           (rsp_chan),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("serial_line_assembler regression: fail");
         $finish;
      end
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Receiver side: ready follows random stall runs, or drops for the
   // whole of a long hold-off when the hold process asks for one.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_active) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap(receiver_stalls);
         end
      end
   end

   // Hold-off counter, kept apart from the stimulus so the sender keeps
   // offering bytes while the output side is blocked.
   initial begin
      hold_active = 0;
      wait (hold_request);
      @(posedge clock);
      hold_active = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 0;
   end

   // One input transfer: optional gap first, then hold valid until ready.
   task automatic send_byte(logic [BYTE_W-1:0] b, logic room);
      int gap;
      gap = pick_gap(sender_idles);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.rx_byte        <= b;
      req_chan.queue_has_room <= room;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Sender pause: stop offering, wait until every predicted char is seen.
   task automatic wait_for_lines();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (chars_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] printable_byte();
      return BYTE_W'($urandom_range(CH_LOW, CH_HIGH));
   endfunction

   // Control codes other than return, or anything with the top bit set.
   function automatic logic [BYTE_W-1:0] noise_byte();
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 1)) begin
         b = BYTE_W'($urandom_range(8'h80, 8'hFF));
      end else begin
         b = BYTE_W'($urandom_range(8'h00, 8'h1F));
         if (b == CH_RETURN)
            b = 8'h1F;
      end
      return b;
   endfunction

   initial begin
      int line_len;
      int r;
      int random_count;
      logic [BYTE_W-1:0] b;

      reset                   <= 1'b1;
      flush_check             <= 1'b0;
      req_chan.valid          <= 1'b0;
      req_chan.rx_byte        <= '0;
      req_chan.queue_has_room <= 1'b0;
      hold_request            = 0;
      sender_idles            = 1;
      receiver_stalls         = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-line return and delete, both printable edges,
      // a delete that takes one back, ignored controls and high bytes,
      // dropped bytes with no room, then two short lines.
      send_byte(CH_RETURN, 1'b1);
      send_byte(CH_DELETE, 1'b1);
      send_byte(CH_LOW, 1'b1);
      send_byte(CH_HIGH, 1'b1);
      send_byte(CH_DELETE, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'h1F, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(CH_RETURN, 1'b0);
      send_byte(CH_DELETE, 1'b0);
      send_byte(CH_RETURN, 1'b1);
      send_byte(CH_HIGH, 1'b1);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h7D, 1'b1);
      send_byte(CH_DELETE, 1'b1);
      send_byte(8'h2A, 1'b1);
      send_byte(CH_RETURN, 1'b1);

      // Pressure: sender waits for the output to drain, then a full line
      // goes in while the receiver is held off, so the drain blocks and
      // the input stalls behind it. The bytes after it start a new line.
      wait_for_lines();
      sender_idles    = 0;
      receiver_stalls = 0;
      hold_request    = 1;
      for (int k = 0; k < LINE_CAPACITY + 4; k++)
         send_byte(printable_byte(), 1'b1);
      send_byte(CH_RETURN, 1'b1);
      wait_for_lines();

      // Random lines: mostly well-formed with random content, some noise,
      // dropped bytes and deletes; a few run past the capacity.
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         sender_idles    = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 80)
            line_len = $urandom_range(1, 12);
         else if (r < 95)
            line_len = $urandom_range(13, 40);
         else
            line_len = $urandom_range(LINE_CAPACITY - 4, LINE_CAPACITY + 6);
         for (int k = 0; k < line_len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               send_byte(printable_byte(), 1'b1);
               random_count++;
            end else if (r < 87) begin
               send_byte(CH_DELETE, 1'b1);
               random_count++;
            end else if (r < 93) begin
               send_byte(noise_byte(), 1'b1);
               random_count++;
            end else begin
               b = $urandom_range(0, 1) ? CH_RETURN : printable_byte();
               send_byte(b, 1'b0);
               random_count++;
            end
         end
         r = $urandom_range(0, 99);
         if (r < 90) begin
            send_byte(CH_RETURN, 1'b1);
            random_count++;
         end else if (r < 95) begin
            send_byte(CH_RETURN, 1'b0);
            random_count++;
         end
      end

      receiver_stalls = 0;
      wait_for_lines();
      repeat (DRAIN_CYCLES) @(posedge clock);
      flush_check <= 1'b1;
      repeat (2) @(posedge clock);

      if (mismatch_count == 0)
         $display("serial_line_assembler regression: pass");
      else
         $display("serial_line_assembler regression: fail");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/sla_pkg.sv
rtl/sla_ifs.sv
rtl/sla_datapath.sv
rtl/sla_controller.sv
rtl/serial_line_assembler.sv
test/sla_line_checker.sv
test/tb_top.sv
